### sv/bfbp_pkg.sv
// Package for the best-fit bin packer: value widths, status codes,
// sequencer states and the result word passed from sequencer to top level.
// No dependencies.
package bfbp_pkg;

    localparam int SIZE_BITS    = 16;
    localparam int VAL_W        = SIZE_BITS + 1;
    localparam int BIN_W        = 6;
    localparam int MAX_BINS_DEF = 64;

    localparam logic [VAL_W-1:0] CAP_RESET = VAL_W'(1) << SIZE_BITS;

    typedef enum logic [1:0] {
        STAT_PLACED  = 2'd0,
        STAT_NO_BIN  = 2'd1,
        STAT_TOO_BIG = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_WAIT,
        S_DECIDE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [VAL_W-1:0] rem;
        logic             opened;
        status_t          status;
    } res_t;

endpackage

### sv/best_fit_bin_packer.sv
// Online best-fit bin packer. Each item_size word is placed in the open bin
// with the least remaining capacity that still holds it (lowest bin on a
// tie); if none holds it the next bin opens with bin_capacity, unless all
// MAX_BINS are open. An item passes the check, scan, wait, decide and done
// states before the next is taken; scan and wait are skipped with no bin
// open, and an item larger than the capacity goes from check to done. The
// scan walks the single read port of the capacity store one open bin a
// cycle past one shared pair of comparators. The result word sits in an
// output register, so a new item is taken while the previous result
// waits. Write bin_capacity only while the block is idle. No clearing pass
// after reset. Depends on bfbp_pkg, bfbp_ram and bfbp_seq.
module best_fit_bin_packer
    import bfbp_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [VAL_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [VAL_W-1:0] item_size,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [BIN_W-1:0] bin_number,
    output logic [VAL_W-1:0] remaining_after,
    output logic             opened_new,
    output logic [1:0]       status
);

    localparam int IDX_W = $clog2(MAX_BINS);

    logic [VAL_W-1:0] cap_reg;
    logic             out_valid_reg;
    res_t             out_res_reg;

    logic             res_valid;
    logic             res_ready;
    res_t             res;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [VAL_W-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    // output slot is free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    bfbp_seq #(
        .MAX_BINS (MAX_BINS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .item      (item_size),
        .cap       (cap_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    bfbp_ram #(
        .DEPTH (MAX_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid       = out_valid_reg;
    assign bin_number      = out_res_reg.bin;
    assign remaining_after = out_res_reg.rem;
    assign opened_new      = out_res_reg.opened;
    assign status          = out_res_reg.status;

endmodule

### sv/bfbp_ram.sv
// Remaining-capacity store of the best-fit bin packer: one write port and
// one registered read port. Uses bfbp_pkg for the value width.
module bfbp_ram
    import bfbp_pkg::*;
#(
    parameter  int DEPTH = MAX_BINS_DEF,
    localparam int AW    = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [VAL_W-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [VAL_W-1:0] rdata
);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/bfbp_seq.sv
// Sequencer of the best-fit bin packer: walks the open bins through the
// capacity store, keeps the best fit with one shared comparator pair and
// one shared subtractor, and updates the store. Uses bfbp_pkg.
module bfbp_seq
    import bfbp_pkg::*;
#(
    parameter  int MAX_BINS = MAX_BINS_DEF,
    localparam int IDX_W    = $clog2(MAX_BINS),
    localparam int OPEN_W   = $clog2(MAX_BINS + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [VAL_W-1:0] item,
    input  logic [VAL_W-1:0] cap,
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res,
    output logic             ram_we,
    output logic [IDX_W-1:0] ram_waddr,
    output logic [VAL_W-1:0] ram_wdata,
    output logic             ram_re,
    output logic [IDX_W-1:0] ram_raddr,
    input  logic [VAL_W-1:0] ram_rdata
);

    state_t             state_reg, state_next;
    logic [VAL_W-1:0]   item_reg, item_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic [OPEN_W-1:0]  open_reg, open_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [VAL_W-1:0]   best_rem_reg, best_rem_next;
    res_t               res_reg, res_next;

    logic               fits;
    logic               better;
    logic [VAL_W-1:0]   sub_a;
    logic [VAL_W-1:0]   sub_res;

    function automatic logic [BIN_W-1:0] to_bin(input logic [IDX_W-1:0] idx);
        logic [IDX_W+BIN_W-1:0] wide;
        wide = {{BIN_W{1'b0}}, idx};
        return wide[BIN_W-1:0];
    endfunction

    // shared compare and subtract
    assign fits    = (ram_rdata >= item_reg);
    assign better  = !found_reg || (ram_rdata < best_rem_reg);
    assign sub_a   = found_reg ? best_rem_reg : cap;
    assign sub_res = sub_a - item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            open_reg  <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            open_reg  <= open_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        addr_reg     <= addr_next;
        pend_idx_reg <= pend_idx_next;
        best_idx_reg <= best_idx_next;
        best_rem_reg <= best_rem_next;
        res_reg      <= res_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        addr_next     = addr_reg;
        open_next     = open_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_rem_next = best_rem_reg;
        res_next      = res_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = addr_reg;
        ram_we        = 1'b0;
        ram_waddr     = best_idx_reg;
        ram_wdata     = sub_res;

        // read data of the previous cycle: keep it if it is a tighter fit
        if (pend_reg && fits && better)
        begin
            found_next    = 1'b1;
            best_idx_next = pend_idx_reg;
            best_rem_next = ram_rdata;
        end

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = item;
                    addr_next  = '0;
                    found_next = 1'b0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (item_reg > cap)
                begin
                    res_next   = '{bin: '0, rem: '0, opened: 1'b0, status: STAT_TOO_BIG};
                    state_next = S_DONE;
                end
                else if (open_reg == '0)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ram_re        = 1'b1;
                pend_next     = 1'b1;
                pend_idx_next = addr_reg;
                addr_next     = addr_reg + 1'b1;
                if (OPEN_W'(addr_reg) == open_reg - 1'b1)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                // last read word is compared in this cycle
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = best_idx_reg;
                    res_next  = '{bin: to_bin(best_idx_reg), rem: sub_res,
                                  opened: 1'b0, status: STAT_PLACED};
                end
                else if (open_reg == OPEN_W'(MAX_BINS))
                begin
                    res_next = '{bin: '0, rem: '0, opened: 1'b0, status: STAT_NO_BIN};
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = open_reg[IDX_W-1:0];
                    open_next = open_reg + 1'b1;
                    res_next  = '{bin: to_bin(open_reg[IDX_W-1:0]), rem: sub_res,
                                  opened: 1'b1, status: STAT_PLACED};
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

### sv/bfbp_checker.sv
// Port-level checks for the best-fit bin packer, bound to the top level.
// Depends on bfbp_pkg and best_fit_bin_packer.
module bfbp_checker
    import bfbp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [BIN_W-1:0] bin_number,
    input logic [VAL_W-1:0] remaining_after,
    input logic             opened_new,
    input logic [1:0]       status
);

    // after an accepted word the input stays closed through the check state and the state that follows it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input taken again too soon after a word");

    // a word that was not placed carries zeroed bin fields
    a_reject_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STAT_PLACED) |->
            (bin_number == '0) && (remaining_after == '0) && !opened_new)
        else $error("rejected word carries non-zero bin fields");

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bin_number) &&
            $stable(remaining_after) && $stable(opened_new) && $stable(status))
        else $error("result word changed while stalled");

endmodule

bind best_fit_bin_packer bfbp_checker u_bfbp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .bin_number      (bin_number),
    .remaining_after (remaining_after),
    .opened_new      (opened_new),
    .status          (status)
);

### sim/tb_best_fit_bin_packer.sv
`timescale 1ns / 100ps
// Self-checking bench for best_fit_bin_packer: a directed table, then random
// sizes under three capacity settings, each result word checked against its
// table entry or a local best-fit predictor. Depends on bfbp_pkg and the packer RTL.
module tb_best_fit_bin_packer;
    import bfbp_pkg::*;

    localparam int BIN_SLOTS     = MAX_BINS_DEF;
    localparam int BLOCK_LATENCY = BIN_SLOTS + 5;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_ITEMS  = 160;
    localparam int PLAN_ROWS     = 23;
    localparam int REPORT_LIMIT  = 10;

    typedef enum bit {ROW_ITEM, ROW_CAP} row_kind_t;

    typedef struct {
        row_kind_t kind;
        logic [VAL_W-1:0] value;
        bit typed;
        res_t want;
    } plan_row_t;

    localparam res_t BY_MODEL = '{bin: '0, rem: '0, opened: 1'b0, status: STAT_PLACED};

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [VAL_W-1:0] cfg_wr_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [VAL_W-1:0] item_size = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [BIN_W-1:0] bin_number;
    logic [VAL_W-1:0] remaining_after;
    logic             opened_new;
    logic [1:0]       status;

    // predictor state: capacity register and remaining room per open bin
    logic [VAL_W-1:0] capacity = CAP_RESET;
    logic [VAL_W-1:0] bin_left [BIN_SLOTS];
    int               n_open = 0;

    res_t placements_due [$];
    plan_row_t plan [PLAN_ROWS];

    int tx_idle_pct = 10;
    int rx_idle_pct = 49;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    int mismatch_count = 0;
    int items_sent = 0;
    int placed_count = 0;
    int opened_count = 0;
    int too_big_count = 0;
    int no_bin_count = 0;

    best_fit_bin_packer uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .item_size       (item_size),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .bin_number      (bin_number),
        .remaining_after (remaining_after),
        .opened_new      (opened_new),
        .status          (status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic res_t place_item(input logic [VAL_W-1:0] sz);
        res_t r;
        int   best;
        bit   found;
        r = BY_MODEL;
        best = 0;
        found = 1'b0;
        if (sz > capacity)
        begin
            r.status = STAT_TOO_BIG;
            return r;
        end
        for (int i = 0; i < n_open; i++)
        begin
            if (bin_left[i] >= sz && (!found || bin_left[i] < bin_left[best]))
            begin
                best = i;
                found = 1'b1;
            end
        end
        if (found)
        begin
            bin_left[best] = bin_left[best] - sz;
            r.bin = BIN_W'(best);
            r.rem = bin_left[best];
            return r;
        end
        if (n_open >= BIN_SLOTS)
        begin
            r.status = STAT_NO_BIN;
            return r;
        end
        bin_left[n_open] = capacity - sz;
        r.bin = BIN_W'(n_open);
        r.rem = bin_left[n_open];
        r.opened = 1'b1;
        n_open++;
        return r;
    endfunction

    // Mostly sizes that can land somewhere, with exact fits to hit the
    // equality edge, plus zero and oversized words as noise.
    function automatic logic [VAL_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return VAL_W'($urandom_range(32'h1FFFF, int'(capacity) + 1));
        if (roll < 36 && n_open > 0)
            return bin_left[$urandom_range(n_open - 1)];
        if (roll < 44)
            return capacity;
        if (roll < 74)
            return VAL_W'($urandom_range(int'(capacity) / 8));
        return VAL_W'($urandom_range(int'(capacity)));
    endfunction

    task automatic send_size(input logic [VAL_W-1:0] sz, input bit typed, input res_t want);
        res_t guess;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        item_size <= sz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        guess = place_item(sz);
        placements_due.insert(placements_due.size(), typed ? want : guess);
        items_sent++;
        case (guess.status)
            STAT_TOO_BIG: too_big_count++;
            STAT_NO_BIN:  no_bin_count++;
            default:
            begin
                placed_count++;
                if (guess.opened)
                    opened_count++;
            end
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (placements_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [VAL_W-1:0] v);
        drain();
        repeat (BLOCK_LATENCY) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        capacity = v;
    endtask

    // result side: check each accepted word, then choose out_ready
    always @(posedge clk)
    begin : result_side
        res_t got;
        res_t want;
        bit   bad;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{bin: bin_number, rem: remaining_after, opened: opened_new,
                        status: status_t'(status)};
                if (placements_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result word with nothing pending: bin %0d rem %0d",
                                 $realtime, got.bin, got.rem);
                end
                else
                begin
                    want = placements_due.pop_front();
                    bad = (got.bin != want.bin) || (got.rem != want.rem)
                        || (got.opened != want.opened) || (got.status != want.status);
                    if (bad)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: expected bin %0d rem %0d opened %0d status %0d",
                                     $realtime, want.bin, want.rem, want.opened,
                                     want.status);
                            $display("%0t: actual   bin %0d rem %0d opened %0d status %0d",
                                     $realtime, got.bin, got.rem, got.opened,
                                     got.status);
                        end
                    end
                end
            end
            if (hold_requests != holds_served)
            begin
                holds_served <= holds_served + 1;
                hold_left <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        plan = '{
            '{ROW_ITEM, 17'd0,       1'b1, '{6'd0, 17'd65536, 1'b1, STAT_PLACED}},
            '{ROW_ITEM, 17'd65536,   1'b1, '{6'd0, 17'd0,     1'b0, STAT_PLACED}},
            '{ROW_ITEM, 17'd65537,   1'b1, '{6'd0, 17'd0,     1'b0, STAT_TOO_BIG}},
            '{ROW_ITEM, 17'h1FFFF,   1'b1, '{6'd0, 17'd0,     1'b0, STAT_TOO_BIG}},
            '{ROW_ITEM, 17'd0,       1'b1, '{6'd0, 17'd0,     1'b0, STAT_PLACED}},
            '{ROW_ITEM, 17'd1,       1'b1, '{6'd1, 17'd65535, 1'b1, STAT_PLACED}},
            '{ROW_ITEM, 17'h08000,   1'b0, BY_MODEL},
            '{ROW_ITEM, 17'h07FFF,   1'b0, BY_MODEL},
            '{ROW_CAP,  17'd0,       1'b0, BY_MODEL},
            '{ROW_ITEM, 17'd0,       1'b0, BY_MODEL},
            '{ROW_ITEM, 17'd1,       1'b1, '{6'd0, 17'd0,     1'b0, STAT_TOO_BIG}},
            '{ROW_CAP,  17'd1,       1'b0, BY_MODEL},
            '{ROW_ITEM, 17'd1,       1'b0, BY_MODEL},
            '{ROW_ITEM, 17'd2,       1'b1, '{6'd0, 17'd0,     1'b0, STAT_TOO_BIG}},
            '{ROW_CAP,  17'd65535,   1'b0, BY_MODEL},
            '{ROW_ITEM, 17'h0C000,   1'b0, BY_MODEL},
            '{ROW_ITEM, 17'h0C000,   1'b0, BY_MODEL},
            '{ROW_ITEM, 17'h01000,   1'b0, BY_MODEL},
            '{ROW_ITEM, 17'h02000,   1'b0, BY_MODEL},
            '{ROW_ITEM, 17'h0FFFF,   1'b0, BY_MODEL},
            '{ROW_ITEM, 17'd65536,   1'b1, '{6'd0, 17'd0,     1'b0, STAT_TOO_BIG}},
            '{ROW_CAP,  17'd65536,   1'b0, BY_MODEL},
            '{ROW_ITEM, 17'h03FFF,   1'b0, BY_MODEL}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_CAP)
                write_capacity(plan[r].value);
            else
                send_size(plan[r].value, plan[r].typed, plan[r].want);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    write_capacity(CAP_RESET);
                    tx_idle_pct = 10;
                    rx_idle_pct = 49;
                end
                1:
                begin
                    write_capacity(17'd65535);
                    tx_idle_pct = 49;
                    rx_idle_pct = 10;
                end
                default:
                begin
                    write_capacity(VAL_W'($urandom_range(60000, 100)));
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                // stall the result side while words keep coming, to back up the input
                if (phase == 0 && n == 40)
                    hold_requests <= hold_requests + 1;
                if (phase == 1 && n == RANDOM_ITEMS / 2)
                    drain();
                send_size(pick_size(), 1'b0, BY_MODEL);
            end
        end

        // open whatever bins remain, then offer three more words of the full capacity
        while (n_open < BIN_SLOTS)
            send_size(capacity, 1'b0, BY_MODEL);
        repeat (3) send_size(capacity, 1'b0, BY_MODEL);

        drain();
        repeat (BLOCK_LATENCY) @(posedge clk);
        mismatch_count += placements_due.size();

        $display("Sent %0d words over five capacity settings: %0d placed (%0d opening bins),",
                 items_sent, placed_count, opened_count);
        $display("%0d oversized, %0d refused with all %0d bins open; %0d mismatches.",
                 too_big_count, no_bin_count, n_open, mismatch_count);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
